FILE: rtl/orsp_pkg.sv
// ----------------------------------------------------------------------------
// orsp_pkg
// shared types and codes of the opcode record stream parser
// ----------------------------------------------------------------------------
package orsp_pkg;

    localparam int RECOLOR_ENTRIES_DEF = 10;

    // parser phases
    localparam logic [2:0] PH_OPCODE = 3'd0;
    localparam logic [2:0] PH_WIDE1  = 3'd1;
    localparam logic [2:0] PH_WIDE2  = 3'd2;
    localparam logic [2:0] PH_NARROW = 3'd3;
    localparam logic [2:0] PH_SKIP   = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // error codes
    localparam logic [1:0] ERR_TRAILING = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN  = 2'd1;
    localparam logic [1:0] ERR_NO_TERM  = 2'd2;
    localparam logic [1:0] ERR_TRUNC    = 2'd3;

    // field codes
    localparam logic [3:0] FC_MODEL     = 4'd0;
    localparam logic [3:0] FC_SEQUENCE  = 4'd1;
    localparam logic [3:0] FC_RECOL_SRC = 4'd7;
    localparam logic [3:0] FC_RECOL_DST = 4'd8;

    // opcodes
    localparam logic [7:0] OP_END       = 8'd0;
    localparam logic [7:0] OP_MODEL     = 8'd1;
    localparam logic [7:0] OP_SEQUENCE  = 8'd2;
    localparam logic [7:0] OP_SCALE_X   = 8'd4;
    localparam logic [7:0] OP_SCALE_Y   = 8'd5;
    localparam logic [7:0] OP_ROTATION  = 8'd6;
    localparam logic [7:0] OP_AMBIENT   = 8'd7;
    localparam logic [7:0] OP_CONTRAST  = 8'd8;
    localparam logic [7:0] OP_FC_OFFSET = 8'd2;
    localparam logic [7:0] OP_RECOL_SRC = 8'd40;
    localparam logic [7:0] OP_RECOL_DST = 8'd50;
    localparam logic [7:0] OP_RECOL_END = 8'd60;

    localparam logic [15:0] ID_ABSENT = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  field_code;
        logic [3:0]  entry_index;
        logic [15:0] field_value;
        logic        absent;
        logic [1:0]  error_code;
    } t_result;

    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] held_opcode;
        logic [7:0] first_byte;
    } t_parse_state;

endpackage

FILE: rtl/orsp_decode.sv
// ----------------------------------------------------------------------------
// orsp_decode
// next-state and result logic for one payload byte
// ----------------------------------------------------------------------------
module orsp_decode #(
    parameter int RECOLOR_ENTRIES = orsp_pkg::RECOLOR_ENTRIES_DEF
) (
    input  orsp_pkg::t_parse_state i_state,
    input  logic                   i_big_endian,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_last_byte,
    output orsp_pkg::t_parse_state o_state,
    output logic                   o_emit,
    output orsp_pkg::t_result      o_result
);

    localparam logic [7:0] SRC_END = 8'(int'(orsp_pkg::OP_RECOL_SRC) + RECOLOR_ENTRIES);
    localparam logic [7:0] DST_END = 8'(int'(orsp_pkg::OP_RECOL_DST) + RECOLOR_ENTRIES);

    logic        op_wide;
    logic        op_narrow;
    logic [7:0]  held;
    logic [7:0]  op_minus;
    logic [7:0]  src_idx;
    logic [7:0]  dst_idx;
    logic [15:0] value;
    orsp_pkg::t_result wr;

    assign held = i_state.held_opcode;

    // width class of the incoming opcode byte
    always_comb begin
        op_wide = (i_data_byte == orsp_pkg::OP_MODEL)    ||
                  (i_data_byte == orsp_pkg::OP_SEQUENCE) ||
                  (i_data_byte == orsp_pkg::OP_SCALE_X)  ||
                  (i_data_byte == orsp_pkg::OP_SCALE_Y)  ||
                  (i_data_byte == orsp_pkg::OP_ROTATION) ||
                  ((i_data_byte >= orsp_pkg::OP_RECOL_SRC) && (i_data_byte < SRC_END)) ||
                  ((i_data_byte >= orsp_pkg::OP_RECOL_DST) && (i_data_byte < DST_END));
        op_narrow = (i_data_byte == orsp_pkg::OP_AMBIENT) ||
                    (i_data_byte == orsp_pkg::OP_CONTRAST);
    end

    // field write built from the held opcode
    always_comb begin
        op_minus = held - orsp_pkg::OP_FC_OFFSET;
        src_idx  = held - orsp_pkg::OP_RECOL_SRC;
        dst_idx  = held - orsp_pkg::OP_RECOL_DST;
        if (i_state.phase == orsp_pkg::PH_WIDE2) begin
            value = i_big_endian ? {i_state.first_byte, i_data_byte}
                                 : {i_data_byte, i_state.first_byte};
        end else begin
            value = {8'd0, i_data_byte};
        end
        wr             = '0;
        wr.kind        = orsp_pkg::KIND_WRITE;
        wr.field_value = value;
        if (held == orsp_pkg::OP_MODEL) begin
            wr.field_code = orsp_pkg::FC_MODEL;
        end else if (held == orsp_pkg::OP_SEQUENCE) begin
            wr.field_code = orsp_pkg::FC_SEQUENCE;
        end else if ((held >= orsp_pkg::OP_SCALE_X) && (held <= orsp_pkg::OP_CONTRAST)) begin
            wr.field_code = op_minus[3:0];
        end else if ((held >= orsp_pkg::OP_RECOL_SRC) && (held < orsp_pkg::OP_RECOL_DST)) begin
            wr.field_code  = orsp_pkg::FC_RECOL_SRC;
            wr.entry_index = src_idx[3:0];
        end else if ((held >= orsp_pkg::OP_RECOL_DST) && (held < orsp_pkg::OP_RECOL_END)) begin
            wr.field_code  = orsp_pkg::FC_RECOL_DST;
            wr.entry_index = dst_idx[3:0];
        end
        wr.absent = ((held == orsp_pkg::OP_MODEL) || (held == orsp_pkg::OP_SEQUENCE)) &&
                    (value == orsp_pkg::ID_ABSENT);
    end

    always_comb begin
        o_state  = i_state;
        o_emit   = 1'b0;
        o_result = '0;
        case (i_state.phase)
            orsp_pkg::PH_OPCODE: begin
                o_emit = 1'b1;
                if (i_data_byte == orsp_pkg::OP_END) begin
                    if (i_last_byte) begin
                        o_result.kind = orsp_pkg::KIND_DONE;
                        o_state.phase = orsp_pkg::PH_OPCODE;
                    end else begin
                        o_result.kind       = orsp_pkg::KIND_ERROR;
                        o_result.error_code = orsp_pkg::ERR_TRAILING;
                        o_state.phase       = orsp_pkg::PH_SKIP;
                    end
                end else if (!op_wide && !op_narrow) begin
                    o_result.kind       = orsp_pkg::KIND_ERROR;
                    o_result.error_code = orsp_pkg::ERR_UNKNOWN;
                    o_state.phase = i_last_byte ? orsp_pkg::PH_OPCODE : orsp_pkg::PH_SKIP;
                end else if (i_last_byte) begin
                    o_result.kind       = orsp_pkg::KIND_ERROR;
                    o_result.error_code = orsp_pkg::ERR_TRUNC;
                    o_state.phase       = orsp_pkg::PH_OPCODE;
                end else begin
                    o_emit              = 1'b0;
                    o_state.held_opcode = i_data_byte;
                    o_state.phase = op_wide ? orsp_pkg::PH_WIDE1 : orsp_pkg::PH_NARROW;
                end
            end
            orsp_pkg::PH_WIDE1: begin
                if (i_last_byte) begin
                    o_emit              = 1'b1;
                    o_result.kind       = orsp_pkg::KIND_ERROR;
                    o_result.error_code = orsp_pkg::ERR_TRUNC;
                    o_state.phase       = orsp_pkg::PH_OPCODE;
                end else begin
                    o_state.first_byte = i_data_byte;
                    o_state.phase      = orsp_pkg::PH_WIDE2;
                end
            end
            orsp_pkg::PH_WIDE2, orsp_pkg::PH_NARROW: begin
                o_emit        = 1'b1;
                o_state.phase = orsp_pkg::PH_OPCODE;
                if (i_last_byte) begin
                    o_result.kind       = orsp_pkg::KIND_ERROR;
                    o_result.error_code = orsp_pkg::ERR_NO_TERM;
                end else begin
                    o_result = wr;
                end
            end
            default: begin
                if (i_last_byte) begin
                    o_state.phase = orsp_pkg::PH_OPCODE;
                end
            end
        endcase
    end

endmodule

FILE: rtl/opcode_record_stream_parser.sv
// ----------------------------------------------------------------------------
// opcode_record_stream_parser
// parses opcode-tagged records from a byte stream into field writes,
// done and error results
// ----------------------------------------------------------------------------
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  in       | i_in_valid / o_in_ready, byte    | request in
//  out      | o_out_valid / i_out_ready, result| request out
//  cfg      | i_cfg_we, i_cfg_data             | write only
//
//  one byte per cycle sustained while the result output is not stalled; a result
//  passes the input register, then the result register
//  synchronous active-low reset returns the parser to expect opcode and
//  sets big-endian order
//  a stalled result holds the parse stage; the input register still takes
//  one more byte, so input ready drops only when both stages are full
// ----------------------------------------------------------------------------
module opcode_record_stream_parser #(
    parameter int RECOLOR_ENTRIES = orsp_pkg::RECOLOR_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_field_code,
    output logic [3:0]  o_entry_index,
    output logic [15:0] o_field_value,
    output logic        o_absent,
    output logic [1:0]  o_error_code
);

    logic                   r_big_endian;
    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_last;
    orsp_pkg::t_parse_state r_state;
    orsp_pkg::t_parse_state n_state;
    logic                   r_out_valid;
    orsp_pkg::t_result      r_result;
    orsp_pkg::t_result      n_result;
    logic                   emit;
    logic                   advance;

    orsp_decode #(
        .RECOLOR_ENTRIES (RECOLOR_ENTRIES)
    ) u_decode (
        .i_state      (r_state),
        .i_big_endian (r_big_endian),
        .i_data_byte  (r_in_byte),
        .i_last_byte  (r_in_last),
        .o_state      (n_state),
        .o_emit       (emit),
        .o_result     (n_result)
    );

    // parse stage moves unless it has a result and the output slot is held
    assign advance    = r_in_valid && (!emit || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_endian <= 1'b1;
        end else if (i_cfg_we) begin
            r_big_endian <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= orsp_pkg::PH_OPCODE;
            r_state.held_opcode <= '0;
            r_state.first_byte  <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_result.kind;
    assign o_field_code  = r_result.field_code;
    assign o_entry_index = r_result.entry_index;
    assign o_field_value = r_result.field_value;
    assign o_absent      = r_result.absent;
    assign o_error_code  = r_result.error_code;

endmodule
